// ----- design/biq_pkg.sv -----
package biq_pkg;

    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CH_W       = 3;
    localparam int RAW_W      = 16;
    localparam int OUT_W      = 24;
    localparam int OUT_FRAC   = 8;
    localparam int COEF_W     = 32;
    localparam int FRAC_SHIFT = 30;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd42016;
    localparam logic signed [COEF_W-1:0] B1_RESET = 32'sd84031;
    localparam logic signed [COEF_W-1:0] B2_RESET = 32'sd42016;
    localparam logic signed [COEF_W-1:0] A1_RESET = -32'sd2128371043;
    localparam logic signed [COEF_W-1:0] A2_RESET = 32'sd1054843968;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic             in_range;
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [OUT_W-1:0] filtered;
    } result_t;

endpackage

// ----- design/biq_fifo.sv -----
module biq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty,
    output logic [CNT_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10: count_next = count_reg + 1'b1;
            2'b01: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("item written into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("item taken from an empty queue");

endmodule

// ----- design/biq_front.sv -----
module biq_front import biq_pkg::*; #(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [RAW_W-1:0] s_axis_tdata,
    input  logic [CH_W-1:0]  s_axis_tuser,
    output logic             q_valid,
    input  logic             q_pop,
    output item_t            q_item
);

    item_t in_item;
    logic  q_full;

    // tag the item so the back end can skip history work for unknown channels
    always_comb begin
        in_item.in_range = (int'(s_axis_tuser) < CHANNELS);
        in_item.channel  = s_axis_tuser;
        in_item.sample   = s_axis_tdata;
    end

    assign s_axis_tready = !q_full;

    biq_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_axis_tvalid && !q_full),
        .push_data (in_item),
        .pop       (q_pop),
        .pop_data  (q_item),
        .full      (q_full),
        .not_empty (q_valid),
        .count     ()
    );

endmodule

// ----- design/biq_back.sv -----
module biq_back import biq_pkg::*; #(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    input  logic [OUT_CNT_W-1:0] out_count,
    output logic                 res_push,
    output result_t              res
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XP_W   = COEF_W + SAMPLE_BITS;
    localparam int YP_W   = COEF_W + OUT_W;
    localparam int FF_W   = XP_W + 2;
    localparam int FB_W   = YP_W + 1;
    localparam int SUM_W  = ((FF_W + OUT_FRAC > FB_W) ? FF_W + OUT_FRAC : FB_W) + 2;
    localparam int Y_W    = SUM_W - FRAC_SHIFT;
    localparam int HIST_W = 2 * SAMPLE_BITS + 2 * OUT_W;
    localparam int INF_W  = OUT_CNT_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (FRAC_SHIFT - 1));

    // coefficients
    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= B0_RESET;
            b1_reg <= B1_RESET;
            b2_reg <= B2_RESET;
            a1_reg <= A1_RESET;
            a2_reg <= A2_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_B0: b0_reg <= cfg_data;
                REG_B1: b1_reg <= cfg_data;
                REG_B2: b2_reg <= cfg_data;
                REG_A1: a1_reg <= cfg_data;
                REG_A2: a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic                           s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic                           s1_inr_reg, s2_inr_reg, s3_inr_reg, s4_inr_reg;
    logic [CH_W-1:0]                s1_ch_reg, s2_ch_reg, s3_ch_reg, s4_ch_reg;
    logic [IDX_W-1:0]               s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic signed [SAMPLE_BITS-1:0]  s1_x_reg, s2_x_reg, s3_x_reg, s4_x_reg;
    logic signed [SAMPLE_BITS-1:0]  s2_x1_reg, s3_x1_reg, s4_x1_reg;
    logic signed [OUT_W-1:0]        s2_y1_reg, s3_y1_reg, s4_y1_reg;
    logic                           hist_vld_reg;
    logic [HIST_W-1:0]              hist_rd_reg;
    logic signed [XP_W-1:0]         s2_p0_reg, s2_p1_reg, s2_p2_reg;
    logic signed [YP_W-1:0]         s2_p3_reg, s2_p4_reg;
    logic signed [FF_W-1:0]         s3_ff_reg;
    logic signed [FB_W-1:0]         s3_fb_reg;
    logic signed [SUM_W-1:0]        s4_sum_reg;

    // history store
    logic [HIST_W-1:0]   hist_mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;

    // issue control
    logic                          hazard, credit_ok, issue, hist_wr;
    logic [INF_W-1:0]              inflight;
    logic [IDX_W-1:0]              issue_idx;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic                          stage_clash;

    assign issue_idx = IDX_W'(q_item.channel);
    assign x_in      = SAMPLE_BITS'(q_item.sample);

    // hold an item while an earlier item of its channel has not written back
    always_comb begin
        hazard = q_item.in_range && (
                 (s1_vld_reg && s1_inr_reg && s1_ch_reg == q_item.channel) ||
                 (s2_vld_reg && s2_inr_reg && s2_ch_reg == q_item.channel) ||
                 (s3_vld_reg && s3_inr_reg && s3_ch_reg == q_item.channel) ||
                 (s4_vld_reg && s4_inr_reg && s4_ch_reg == q_item.channel));
        inflight = INF_W'(s1_vld_reg) + INF_W'(s2_vld_reg)
                 + INF_W'(s3_vld_reg) + INF_W'(s4_vld_reg);
        credit_ok = (INF_W'(out_count) + inflight) < INF_W'(OUT_DEPTH);
        issue     = q_valid && !hazard && credit_ok;
    end

    assign q_pop = issue;

    // stage 1: history read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_inr_reg <= q_item.in_range;
            s1_ch_reg  <= q_item.channel;
            s1_idx_reg <= issue_idx;
            s1_x_reg   <= x_in;
        end
        if (issue && q_item.in_range) begin
            hist_vld_reg <= vld_reg[issue_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_wr) begin
            hist_mem[s4_idx_reg] <= {s4_x_reg, s4_x1_reg, res.filtered, s4_y1_reg};
        end
        if (issue && q_item.in_range) begin
            hist_rd_reg <= hist_mem[issue_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (hist_wr) begin
            vld_reg[s4_idx_reg] <= 1'b1;
        end
    end

    // stage 2: five products
    logic signed [SAMPLE_BITS-1:0] x1_h, x2_h;
    logic signed [OUT_W-1:0]       y1_h, y2_h;

    always_comb begin
        if (hist_vld_reg) begin
            {x1_h, x2_h, y1_h, y2_h} = hist_rd_reg;
        end else begin
            {x1_h, x2_h, y1_h, y2_h} = '0;
        end
    end

    always_ff @(posedge aclk) begin
        s2_inr_reg <= s1_inr_reg;
        s2_ch_reg  <= s1_ch_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_x_reg   <= s1_x_reg;
        s2_x1_reg  <= x1_h;
        s2_y1_reg  <= y1_h;
        s2_p0_reg  <= XP_W'(b0_reg) * XP_W'(s1_x_reg);
        s2_p1_reg  <= XP_W'(b1_reg) * XP_W'(x1_h);
        s2_p2_reg  <= XP_W'(b2_reg) * XP_W'(x2_h);
        s2_p3_reg  <= YP_W'(a1_reg) * YP_W'(y1_h);
        s2_p4_reg  <= YP_W'(a2_reg) * YP_W'(y2_h);
    end

    // stage 3: feed-forward and feedback sums
    always_ff @(posedge aclk) begin
        s3_inr_reg <= s2_inr_reg;
        s3_ch_reg  <= s2_ch_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_x_reg   <= s2_x_reg;
        s3_x1_reg  <= s2_x1_reg;
        s3_y1_reg  <= s2_y1_reg;
        s3_ff_reg  <= FF_W'(s2_p0_reg) + FF_W'(s2_p1_reg) + FF_W'(s2_p2_reg);
        s3_fb_reg  <= FB_W'(s2_p3_reg) + FB_W'(s2_p4_reg);
    end

    // stage 4: align feed-forward to 38 fraction bits, subtract feedback, round
    always_ff @(posedge aclk) begin
        s4_inr_reg <= s3_inr_reg;
        s4_ch_reg  <= s3_ch_reg;
        s4_idx_reg <= s3_idx_reg;
        s4_x_reg   <= s3_x_reg;
        s4_x1_reg  <= s3_x1_reg;
        s4_y1_reg  <= s3_y1_reg;
        s4_sum_reg <= (SUM_W'(s3_ff_reg) <<< OUT_FRAC) - SUM_W'(s3_fb_reg) + ROUND_HALF;
    end

    // floor shift, saturate, write back and emit
    logic signed [Y_W-1:0]   y_full;
    logic [Y_W-OUT_W:0]      y_hi;
    logic signed [OUT_W-1:0] y_sat;

    always_comb begin
        y_full = s4_sum_reg[SUM_W-1:FRAC_SHIFT];
        y_hi   = y_full[Y_W-1:OUT_W-1];
        if ((&y_hi) || !(|y_hi)) begin
            y_sat = y_full[OUT_W-1:0];
        end else if (y_full[Y_W-1]) begin
            y_sat = OUT_MIN;
        end else begin
            y_sat = OUT_MAX;
        end
        res.channel  = s4_ch_reg;
        res.filtered = s4_inr_reg ? y_sat : '0;
    end

    assign hist_wr  = s4_vld_reg && s4_inr_reg;
    assign res_push = s4_vld_reg;

    always_comb begin
        stage_clash =
            (s1_vld_reg && s1_inr_reg && s2_vld_reg && s2_inr_reg && s1_ch_reg == s2_ch_reg) ||
            (s1_vld_reg && s1_inr_reg && s3_vld_reg && s3_inr_reg && s1_ch_reg == s3_ch_reg) ||
            (s1_vld_reg && s1_inr_reg && s4_vld_reg && s4_inr_reg && s1_ch_reg == s4_ch_reg) ||
            (s2_vld_reg && s2_inr_reg && s3_vld_reg && s3_inr_reg && s2_ch_reg == s3_ch_reg) ||
            (s2_vld_reg && s2_inr_reg && s4_vld_reg && s4_inr_reg && s2_ch_reg == s4_ch_reg) ||
            (s3_vld_reg && s3_inr_reg && s4_vld_reg && s4_inr_reg && s3_ch_reg == s4_ch_reg);
    end

    a_one_per_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        !stage_clash)
        else $error("two items of one channel in the pipeline");

    a_result_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (INF_W'(out_count) + inflight) <= INF_W'(OUT_DEPTH))
        else $error("more items in flight than result queue room");

    a_pipe_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg |=> s2_vld_reg && s2_ch_reg == $past(s1_ch_reg))
        else $error("pipeline lost or altered an item");

endmodule

// ----- design/multichannel_biquad_lowpass.sv -----
// Second-order IIR low-pass (direct form I) shared by up to CHANNELS sensor
// channels, each with its own two past inputs and outputs, cleared at reset
// by per-channel valid bits (no clearing pass; the block takes items from
// the first cycle after reset). Items are taken into a four-entry input
// queue, then issued into a four-stage datapath: history read, five
// multiplies, feed-forward and feedback sums, round and add; the saturated
// result is written back and placed in an eight-entry result queue.
// One item is issued per cycle as long as the result queue has room for it and
// no earlier item of the same channel is still in the four datapath stages,
// since that item's result becomes the next one's history at write-back: a
// stream with four or more other items between two samples of one channel
// runs at one item per cycle, and a single channel repeated issues each
// item only after the one before it has written back. Items tagged with a
// channel at or above CHANNELS return filtered = 0 and leave all histories
// untouched. Coefficients are signed Q2.30 and should be written only while
// no item is in flight.
module multichannel_biquad_lowpass import biq_pkg::*; #(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    // input samples
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [RAW_W-1:0]     s_axis_tdata,   // [15:0] sample
    input  logic [CH_W-1:0]      s_axis_tuser,   // [2:0] channel
    // filtered results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // [23:0] filtered
    output logic [CH_W-1:0]      m_axis_tuser    // [2:0] channel_out
);

    logic                 q_valid, q_pop;
    item_t                q_item;
    logic                 res_push;
    result_t              res, out_res;
    logic [OUT_CNT_W-1:0] out_count;

    biq_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    biq_back #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (res)
    );

    biq_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .pop       (m_axis_tvalid && m_axis_tready),
        .pop_data  (out_res),
        .full      (),
        .not_empty (m_axis_tvalid),
        .count     (out_count)
    );

    assign m_axis_tdata = out_res.filtered;
    assign m_axis_tuser = out_res.channel;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

import biq_pkg::*;

class lowpass_tracker;
    logic signed [COEF_W-1:0] coef [0:REG_A2];
    logic signed [RAW_W-1:0]  x_hist [DEF_CHANNELS][2];
    logic signed [OUT_W-1:0]  y_hist [DEF_CHANNELS][2];
    result_t                  pending_outputs [$];
    int                       mismatches;

    function new();
        coef[REG_B0] = B0_RESET;
        coef[REG_B1] = B1_RESET;
        coef[REG_B2] = B2_RESET;
        coef[REG_A1] = A1_RESET;
        coef[REG_A2] = A2_RESET;
        for (int c = 0; c < DEF_CHANNELS; c++) begin
            x_hist[c][0] = '0;
            x_hist[c][1] = '0;
            y_hist[c][0] = '0;
            y_hist[c][1] = '0;
        end
        mismatches = 0;
    endfunction

    // drop writes to indexes past the last coefficient
    function void set_coef(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
        if (idx <= REG_A2)
            coef[idx] = value;
    endfunction

    function void take_sample(logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw);
        result_t want;
        longint  acc;
        longint  y;
        want.channel  = ch;
        want.filtered = '0;
        if (ch < DEF_CHANNELS) begin
            // feed-forward has 30 fraction bits, feedback 38: align on 38
            acc = (longint'(coef[REG_B0]) * longint'($signed(raw))
                 + longint'(coef[REG_B1]) * longint'(x_hist[ch][0])
                 + longint'(coef[REG_B2]) * longint'(x_hist[ch][1])) * 256
                 - longint'(coef[REG_A1]) * longint'(y_hist[ch][0])
                 - longint'(coef[REG_A2]) * longint'(y_hist[ch][1]);
            // round half up, then floor away the coefficient fraction
            y = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
            if (y > longint'(OUT_MAX))
                y = longint'(OUT_MAX);
            if (y < longint'(OUT_MIN))
                y = longint'(OUT_MIN);
            x_hist[ch][1] = x_hist[ch][0];
            x_hist[ch][0] = raw;
            y_hist[ch][1] = y_hist[ch][0];
            y_hist[ch][0] = y[OUT_W-1:0];
            want.filtered = y[OUT_W-1:0];
        end
        pending_outputs = {pending_outputs, want};
    endfunction

    function void check_output(logic [CH_W-1:0] ch, logic [OUT_W-1:0] filt);
        result_t want;
        if (pending_outputs.size() == 0) begin
            $error("unexpected item: channel_out %0d filtered %0d", ch, $signed(filt));
            mismatches++;
        end else begin
            want = pending_outputs.pop_front();
            if (ch !== want.channel) begin
                $error("channel_out: expected %0d, got %0d", want.channel, ch);
                mismatches++;
            end
            if (filt !== want.filtered) begin
                $error("filtered: expected %0d, got %0d", want.filtered, $signed(filt));
                mismatches++;
            end
        end
    endfunction

    function int outstanding();
        return pending_outputs.size();
    endfunction
endclass

module tb_top;

    localparam int STUCK_LIMIT = 4000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [RAW_W-1:0]     s_axis_tdata = '0;    // [15:0] sample
    logic [CH_W-1:0]      s_axis_tuser = '0;    // [2:0] channel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;         // [23:0] filtered
    logic [CH_W-1:0]      m_axis_tuser;         // [2:0] channel_out

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_left = 0;
    int stuck_cycles = 0;

    lowpass_tracker tracker = new();

    multichannel_biquad_lowpass u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // hold off for a requested stretch, otherwise stall at random
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.check_output(m_axis_tuser, m_axis_tdata);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx,
                              input logic [COEF_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_coef(idx, value);
    endtask

    task automatic write_all_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                                   input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                                   input logic [COEF_W-1:0] a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
    endtask

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= ch;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        tracker.take_sample(ch, raw);
    endtask

    // drop valid, then wait for every filtered item to come back
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() > 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        int               pick;
        ch = '0;
        for (int i = 0; i < count; i++) begin
            // keep the channel now and then to hit back-to-back history reuse
            if ($urandom_range(99) < 70)
                ch = CH_W'($urandom_range(DEF_CHANNELS - 1));
            pick = $urandom_range(7);
            if (pick < 4)
                raw = RAW_W'($urandom);
            else if (pick < 6)
                raw = RAW_W'($urandom_range(511) - 256);
            else if (pick == 6)
                raw = 16'h7FFF;
            else
                raw = 16'h8000;
            send_sample(ch, raw);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // writes past the last coefficient must change nothing
        for (int idx = REG_A2 + 1; idx < (1 << REG_IDX_W); idx++)
            write_coef(REG_IDX_W'(idx), $urandom);

        // reset coefficients: start-up from clear histories, field extremes
        send_sample(3'd0, 16'h7FFF);
        send_sample(3'd0, 16'h7FFF);
        send_sample(3'd0, 16'h7FFF);
        send_sample(3'd1, 16'h8000);
        send_sample(3'd1, 16'h8000);
        send_sample(3'd1, 16'h8000);
        send_sample(3'd2, 16'h0000);
        send_sample(3'd2, 16'hFFFF);
        send_sample(3'd2, 16'h0001);
        send_sample(3'd3, 16'h5555);
        send_sample(3'd4, 16'hAAAA);
        send_sample(3'd7, 16'h7FFF);
        send_sample(3'd0, 16'h0000);
        drain();

        // extreme coefficients: drive the output into both saturation bounds
        write_all_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000);
        send_sample(3'd5, 16'h7FFF);
        send_sample(3'd5, 16'h7FFF);
        send_sample(3'd5, 16'h7FFF);
        send_sample(3'd6, 16'h8000);
        send_sample(3'd6, 16'h8000);
        send_sample(3'd6, 16'h8000);
        send_sample(3'd5, 16'h0000);
        drain();

        write_all_coefs(B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET);
        send_idle_pct = 87;
        run_random(300);
        drain();

        write_all_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        run_random(200);
        drain();

        write_all_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        run_random(200);
        drain();

        write_all_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(250);
        drain();

        // long receiver hold-off while the sender keeps pushing
        write_all_coefs($urandom_range(1 << 21) - (1 << 20),
                        $urandom_range(1 << 21) - (1 << 20),
                        $urandom_range(1 << 21) - (1 << 20),
                        A1_RESET, A2_RESET);
        hold_off_left = 150;
        run_random(250);
        drain();

        write_all_coefs(B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        run_random(240);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(240);
        drain();

        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
